/* hw/rtl/lexicographic_color_morphology_macros.svh */
// Assertion macros for the lexicographic color morphology block.
// Used by lcm_ctrl; needs clk and rst_n in the scope of the use.
`ifndef LEXICOGRAPHIC_COLOR_MORPHOLOGY_MACROS_SVH
`define LEXICOGRAPHIC_COLOR_MORPHOLOGY_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcm assertion failed");
// next-cycle implication
`define LCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcm assertion failed");
`else
`define LCM_ASSERT_NOW(label, ante, cons)
`define LCM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/lcm_pkg.sv */
// Shared types and constants for the lexicographic color morphology block.
// No dependencies.
package lcm_pkg;
  localparam int SZ_W     = 13;          // frame size and position counters
  localparam int LAG_W    = SZ_W + 2;    // lag counter and window delay
  localparam int PIX_W    = 24;          // packed color, blue in the top byte
  localparam int ROW_SEL_W = 3;          // line store keeps 8 rows
  localparam int IDX_W    = 3;           // scan index, 0 .. 2*radius
  localparam int MASK_W   = 49;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 49;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;

  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic issue;    // read one window position
    logic finish;   // load the result register, advance output position
  } lcm_cmd_t;

  typedef struct packed {
    logic emit;       // accepted item produces a result
    logic scan_last;  // last window position is being read
    logic out_free;   // result register can be loaded
  } lcm_status_t;
endpackage

/* hw/rtl/lexicographic_color_morphology.sv */
// Top level of the lexicographic color erosion / dilation block.
// Depends on lcm_pkg, lcm_ctrl and lcm_datapath.
//
// Channel | direction | handshake          | payload
// in_     | slave     | tvalid/tready      | tdata: red, green, blue; tuser: is_pixel
// out_    | master    | tvalid/tready      | tdata: red, green, blue; tlast: last_of_frame
// cfg_    | slave     | valid/ready        | index, data (register write)
//
// An item that gives no result is taken and leaves the block idle. An item
// that gives a result passes through the scan and drain states: the window is read one
// position per cycle through the single read port of the line store.
// A finished result waits in the output register; the next item is taken
// meanwhile, and the block stalls only when a second result is ready.
// Reset is synchronous and active low; the line store is not cleared.
module lexicographic_color_morphology import lcm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                  in_tuser,   // is_pixel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic                  out_tlast,  // last_of_frame
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  lcm_cmd_t    cmd;
  lcm_status_t status;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  lcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // packed tdata order equals the comparison order: blue most significant
  lcm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_is_pixel (in_tuser),
    .in_pix      (in_tdata),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_pix     (out_tdata),
    .out_last    (out_tlast)
  );
endmodule

/* hw/rtl/lcm_datapath.sv */
// Datapath: config registers, line store, position counters, window scan
// and result register. Depends on lcm_pkg.
module lcm_datapath import lcm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcm_cmd_t              cmd,
  output lcm_status_t           status,
  input  logic                  in_is_pixel,
  input  logic [PIX_W-1:0]      in_pix,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [PIX_W-1:0]      out_pix,
  output logic                  out_last
);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = (1 << ROW_SEL_W) * (1 << CW);
  localparam int AW    = ROW_SEL_W + CW;

  logic [10:0]       width_r, height_r;
  logic [1:0]        radius_r;
  logic [MASK_W-1:0] mask_r;
  logic              mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 11'd1024;
      radius_r <= 2'd1;
      mask_r   <= '1;
      mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_r  <= cfg_wdata[10:0];
        REG_HEIGHT: height_r <= cfg_wdata[10:0];
        REG_RADIUS: radius_r <= cfg_wdata[1:0];
        REG_MASK:   mask_r   <= cfg_wdata[MASK_W-1:0];
        REG_MODE:   mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [SZ_W-1:0]  w, h;
  logic [1:0]       r;
  logic [LAG_W-1:0] delay_r;

  always_comb begin
    w = {{(SZ_W-11){1'b0}}, width_r};
    if (width_r == 11'd0) w = SZ_W'(1);
    else if (w > SZ_W'(MAX_WIDTH)) w = SZ_W'(MAX_WIDTH);
    h = {{(SZ_W-11){1'b0}}, height_r};
    if (height_r == 11'd0) h = SZ_W'(1);
    else if (h > SZ_W'(MAX_HEIGHT)) h = SZ_W'(MAX_HEIGHT);
    r = (radius_r > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : radius_r;
  end

  always_ff @(posedge clk) begin
    delay_r <= LAG_W'(r * w) + LAG_W'(r);
  end

  // position counters
  logic [SZ_W-1:0]  irow_r, icol_r, orow_r, ocol_r;
  logic [LAG_W-1:0] lag_r;
  logic [SZ_W-1:0]  irow_e, icol_e, orow_e, ocol_e;
  logic [LAG_W-1:0] lag_e, lag_inc;
  logic             restart, writing, ignore, emit;

  always_comb begin
    restart = (orow_r >= h);
    irow_e  = restart ? '0 : irow_r;
    icol_e  = restart ? '0 : icol_r;
    orow_e  = restart ? '0 : orow_r;
    ocol_e  = restart ? '0 : ocol_r;
    lag_e   = restart ? '0 : lag_r;
    writing = (irow_e < h);
    ignore  = writing && !in_is_pixel;
    lag_inc = lag_e + LAG_W'(1);
    emit    = !ignore && (lag_inc > delay_r);
  end

  // line store
  logic [PIX_W-1:0] mem [0:DEPTH-1];
  logic [PIX_W-1:0] rd_r;
  logic             rd_valid_r;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             rd_en;

  assign wr_addr = {irow_e[ROW_SEL_W-1:0], icol_e[CW-1:0]};

  // scan indices
  logic [IDX_W-1:0] dyi_r, dxi_r;
  logic [IDX_W-1:0] span;
  logic [SZ_W+1:0]  nrow, ncol;
  logic [IDX_W-1:0] dy_off, dx_off;
  logic [5:0]       bit_idx;
  logic             scan_last;

  always_comb begin
    span    = {r, 1'b0};
    nrow    = {2'b00, orow_r} + (SZ_W+2)'(dyi_r) - (SZ_W+2)'(r);
    ncol    = {2'b00, ocol_r} + (SZ_W+2)'(dxi_r) - (SZ_W+2)'(r);
    dy_off  = dyi_r + IDX_W'(3) - {1'b0, r};
    dx_off  = dxi_r + IDX_W'(3) - {1'b0, r};
    bit_idx = 6'(dy_off) * 6'd7 + 6'(dx_off);
    rd_en   = cmd.issue && !nrow[SZ_W+1] && (nrow[SZ_W-1:0] < h)
              && !ncol[SZ_W+1] && (ncol[SZ_W-1:0] < w)
              && (mask_r[bit_idx] || (dyi_r == {1'b0, r} && dxi_r == {1'b0, r}));
    rd_addr = {nrow[ROW_SEL_W-1:0], ncol[CW-1:0]};
    scan_last = cmd.issue && (dyi_r == span) && (dxi_r == span);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && writing && in_is_pixel) mem[wr_addr] <= in_pix;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  // running extreme
  logic [PIX_W-1:0] best_r, best_nxt;
  logic             best_valid_r;

  always_comb begin
    best_nxt = best_r;
    if (rd_valid_r) begin
      if (!best_valid_r) best_nxt = rd_r;
      else if (mode_r ? (rd_r > best_r) : (rd_r < best_r)) best_nxt = rd_r;
    end
  end

  // output position advance
  logic [SZ_W-1:0] ocol_inc, orow_adv, ocol_adv;
  logic            frame_end;
  always_comb begin
    ocol_inc = ocol_r + SZ_W'(1);
    ocol_adv = (ocol_inc >= w) ? '0 : ocol_inc;
    orow_adv = (ocol_inc >= w) ? orow_r + SZ_W'(1) : orow_r;
    frame_end = (orow_adv >= h);
  end

  logic out_valid_r;
  assign status = '{emit: emit, scan_last: scan_last,
                    out_free: !out_valid_r || out_tready};
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irow_r <= '0; icol_r <= '0; orow_r <= '0; ocol_r <= '0; lag_r <= '0;
      dyi_r <= '0; dxi_r <= '0; rd_valid_r <= 1'b0; best_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
      best_r     <= best_nxt;
      if (rd_valid_r) best_valid_r <= 1'b1;
      if (cmd.accept) begin
        irow_r <= irow_e; icol_r <= icol_e; orow_r <= orow_e; ocol_r <= ocol_e;
        lag_r  <= lag_e;
        dyi_r  <= '0; dxi_r <= '0; best_valid_r <= 1'b0;
        if (!ignore) begin
          lag_r <= emit ? lag_e : lag_inc;
          if (writing) begin
            if (icol_e + SZ_W'(1) >= w) begin
              icol_r <= '0;
              irow_r <= irow_e + SZ_W'(1);
            end else begin
              icol_r <= icol_e + SZ_W'(1);
            end
          end
        end
      end
      if (cmd.issue) begin
        if (dxi_r == span) begin
          dxi_r <= '0;
          dyi_r <= dyi_r + IDX_W'(1);
        end else begin
          dxi_r <= dxi_r + IDX_W'(1);
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        ocol_r <= ocol_adv;
        orow_r <= orow_adv;
        if (frame_end) begin
          irow_r <= '0; icol_r <= '0; orow_r <= '0; ocol_r <= '0; lag_r <= '0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_pix  <= best_nxt;
      out_last <= frame_end;
    end
  end
endmodule

/* hw/rtl/lcm_ctrl.sv */
// Controller: sequences accept, window scan and result hand-off.
// Depends on lcm_pkg and lexicographic_color_morphology_macros.svh.
`include "lexicographic_color_morphology_macros.svh"
module lcm_ctrl import lcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  lcm_status_t status,
  output lcm_cmd_t    cmd
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    in_tready  = (state_r == S_IDLE);
    cmd.accept = in_tvalid && in_tready;
    cmd.issue  = (state_r == S_SCAN);
    cmd.finish = (state_r == S_DRAIN) && status.out_free;
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE:  if (cmd.accept && status.emit) state_nxt = S_SCAN;
      S_SCAN:  if (status.scan_last) state_nxt = S_DRAIN;
      S_DRAIN: if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  `LCM_ASSERT_NEXT(a_emit_scans, cmd.accept && status.emit, state_r == S_SCAN)
  `LCM_ASSERT_NOW(a_finish_free, cmd.finish, status.out_free)
  `LCM_ASSERT_NEXT(a_last_drains, status.scan_last, state_r == S_DRAIN)
endmodule
